// ----- rtl/core/mdr_pkg.sv -----
// Shared types and constants for the modular difference rotation core.
package mdr_pkg;

    localparam int DIFF_W  = 32;
    localparam int ROT_W   = 5;
    localparam int COUNT_W = 33;
    localparam int NCAND   = 4;

    localparam logic [COUNT_W-1:0] FULL_COUNT    = 33'h1_0000_0000;
    localparam logic [COUNT_W-1:0] MIN_COUNT_RST = 33'd1;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic [ROT_W-1:0]  rotation;
    } src_beat_t;

    typedef struct packed {
        logic [DIFF_W-1:0]  rotated_diff;
        logic [COUNT_W-1:0] count;
        logic               is_best;
        logic               none_kept;
        logic               last;
    } dst_beat_t;

    // pairwise compares, gij = count[j] > count[i]
    typedef struct packed {
        logic g01;
        logic g02;
        logic g03;
        logic g12;
        logic g13;
        logic g23;
    } cmp_t;

endpackage

// ----- rtl/core/modular_difference_rotation_core.sv -----
// Rotation of a 32-bit modular difference: candidate list with exact counts.
//
// An input beat (diff, rotation) is taken every cycle the pipeline has room and
// yields one to four result beats, one per cycle unless the output stalls, in
// the order c1..c4; the final beat of an input carries last. The pipeline is
// five stages deep (operand forming, two 32x32 multipliers, count subtraction,
// threshold and pairwise compare, then the result emitter) plus the output
// register. The emitter sets the sustained rate: it takes a new input only once
// all beats of the one before are sent, a single beat for a trivial input or
// when nothing is kept, else one per kept candidate. The user must write
// min_count through cfg_we/cfg_wdata only while idle; the block does not enforce it.
module modular_difference_rotation_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    src_valid,
    output logic                    src_ready,
    input  mdr_pkg::src_beat_t      src_data,
    output logic                    dst_valid,
    input  logic                    dst_ready,
    output mdr_pkg::dst_beat_t      dst_data,
    input  logic                    cfg_we,
    input  logic [mdr_pkg::COUNT_W-1:0] cfg_wdata
);
    import mdr_pkg::*;

    logic [COUNT_W-1:0] min_count_reg;

    // ---------------- stage 1 operand forming (combinational) ----------------
    logic [5:0]          r2;
    logic [COUNT_W-1:0]  lowspan;
    logic [COUNT_W-1:0]  highspan;
    logic [DIFF_W-1:0]   x_c;
    logic [DIFF_W-1:0]   y_c;
    logic [DIFF_W-1:0]   yn_c;
    logic [DIFF_W-1:0]   base_c;
    logic [DIFF_W-1:0]   rot_c;
    logic [DIFF_W-1:0]   rotn_c;
    logic [COUNT_W-1:0]  a0_c;

    always_comb
    begin
        r2       = 6'd32 - {1'b0, src_data.rotation};
        lowspan  = COUNT_W'(1) << r2;
        highspan = COUNT_W'(1) << src_data.rotation;
        x_c      = src_data.diff & (lowspan[DIFF_W-1:0] - 32'd1);
        y_c      = src_data.diff >> r2;
        yn_c     = (y_c + 32'd1) & (highspan[DIFF_W-1:0] - 32'd1);
        base_c   = x_c << src_data.rotation;
        rot_c    = base_c | y_c;
        rotn_c   = base_c | yn_c;
        a0_c     = lowspan - {1'b0, x_c};
    end

    logic                s1_valid_reg;
    logic                s1_triv_reg;
    logic                s1_has4_reg;
    logic [DIFF_W-1:0]   s1_cand_reg [NCAND];
    logic [DIFF_W-1:0]   s1_a0_reg;
    logic [DIFF_W-1:0]   s1_y_reg;
    logic [DIFF_W-1:0]   s1_x_reg;
    logic [DIFF_W-1:0]   s1_yn_reg;
    logic [COUNT_W-1:0]  s1_hl_reg;
    logic [COUNT_W-1:0]  s1_xs_reg;

    logic                s2_valid_reg;
    logic                s2_triv_reg;
    logic                s2_has4_reg;
    logic [DIFF_W-1:0]   s2_cand_reg [NCAND];
    logic [COUNT_W-1:0]  s2_p0_reg;
    logic [COUNT_W-1:0]  s2_p2_reg;
    logic [COUNT_W-1:0]  s2_hl_reg;
    logic [COUNT_W-1:0]  s2_xs_reg;

    logic                s3_valid_reg;
    logic                s3_triv_reg;
    logic                s3_has4_reg;
    logic [DIFF_W-1:0]   s3_cand_reg [NCAND];
    logic [COUNT_W-1:0]  s3_cnt_reg  [NCAND];

    logic                s4_valid_reg;
    logic                s4_triv_reg;
    logic [NCAND-1:0]    s4_keep_reg;
    cmp_t                s4_cmp_reg;
    logic [DIFF_W-1:0]   s4_cand_reg [NCAND];
    logic [COUNT_W-1:0]  s4_cnt_reg  [NCAND];

    logic                em_valid_reg;
    logic                em_triv_reg;
    logic                em_none_reg;
    logic [NCAND-1:0]    em_pend_reg;
    logic [NCAND-1:0]    em_best_reg;
    logic [DIFF_W-1:0]   em_cand_reg [NCAND];
    logic [COUNT_W-1:0]  em_cnt_reg  [NCAND];

    logic                dst_valid_reg;
    dst_beat_t           dst_data_reg;
    dst_beat_t           dst_data_next;

    // ---------------- flow control ----------------
    logic             out_load;
    logic             em_fire;
    logic             em_last;
    logic             en_em;
    logic             en4;
    logic             en3;
    logic             en2;
    logic             en1;
    logic [NCAND-1:0] em_sel;
    logic [1:0]       em_idx;

    assign em_sel   = em_pend_reg & (~em_pend_reg + NCAND'(1));
    assign em_last  = (em_pend_reg & ~em_sel) == '0;
    assign out_load = !dst_valid_reg || dst_ready;
    assign em_fire  = em_valid_reg && out_load;
    assign en_em    = !em_valid_reg || (em_fire && em_last);
    assign en4      = !s4_valid_reg || en_em;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign src_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg <= MIN_COUNT_RST;
        end
        else if (cfg_we)
        begin
            min_count_reg <= cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            em_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= src_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en_em)
            begin
                em_valid_reg <= s4_valid_reg;
            end
            if (out_load)
            begin
                dst_valid_reg <= em_valid_reg;
            end
        end
    end

    // stage 1: split, rotate, multiplier operands
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_triv_reg    <= (src_data.diff == '0) || (src_data.rotation == '0);
            s1_has4_reg    <= (x_c != '0);
            s1_cand_reg[0] <= rot_c - highspan[DIFF_W-1:0];
            s1_cand_reg[1] <= rot_c;
            s1_cand_reg[2] <= rotn_c - highspan[DIFF_W-1:0];
            s1_cand_reg[3] <= rotn_c;
            s1_a0_reg      <= a0_c[DIFF_W-1:0];
            s1_y_reg       <= y_c;
            s1_x_reg       <= x_c;
            s1_yn_reg      <= yn_c;
            s1_hl_reg      <= a0_c << src_data.rotation;
            s1_xs_reg      <= {1'b0, x_c} << src_data.rotation;
        end
    end

    // stage 2: products
    logic [2*DIFF_W-1:0] prod0;
    logic [2*DIFF_W-1:0] prod2;

    assign prod0 = s1_a0_reg * s1_y_reg;
    assign prod2 = s1_x_reg * s1_yn_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_triv_reg <= s1_triv_reg;
            s2_has4_reg <= s1_has4_reg;
            s2_cand_reg <= s1_cand_reg;
            s2_p0_reg   <= prod0[COUNT_W-1:0];
            s2_p2_reg   <= prod2[COUNT_W-1:0];
            s2_hl_reg   <= s1_hl_reg;
            s2_xs_reg   <= s1_xs_reg;
        end
    end

    // stage 3: the complementary counts by subtraction
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_triv_reg   <= s2_triv_reg;
            s3_has4_reg   <= s2_has4_reg;
            s3_cand_reg   <= s2_cand_reg;
            s3_cnt_reg[0] <= s2_p0_reg;
            s3_cnt_reg[1] <= s2_hl_reg - s2_p0_reg;
            s3_cnt_reg[2] <= s2_p2_reg;
            s3_cnt_reg[3] <= s2_xs_reg - s2_p2_reg;
        end
    end

    // stage 4: threshold and pairwise compares
    logic [NCAND-1:0] keep_c;
    cmp_t             cmp_c;

    always_comb
    begin
        for (int i = 0; i < NCAND; i++)
        begin
            keep_c[i] = (s3_cnt_reg[i] >= min_count_reg) && ((i < 2) || s3_has4_reg);
        end
        cmp_c.g01 = s3_cnt_reg[1] > s3_cnt_reg[0];
        cmp_c.g02 = s3_cnt_reg[2] > s3_cnt_reg[0];
        cmp_c.g03 = s3_cnt_reg[3] > s3_cnt_reg[0];
        cmp_c.g12 = s3_cnt_reg[2] > s3_cnt_reg[1];
        cmp_c.g13 = s3_cnt_reg[3] > s3_cnt_reg[1];
        cmp_c.g23 = s3_cnt_reg[3] > s3_cnt_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_triv_reg <= s3_triv_reg;
            s4_keep_reg <= keep_c;
            s4_cmp_reg  <= cmp_c;
            s4_cand_reg <= s3_cand_reg;
            s4_cnt_reg  <= s3_cnt_reg;
        end
    end

    // best pick: earlier kept ones strictly lower, later kept ones not higher
    logic [NCAND-1:0] best_c;
    logic [3:0]       k;
    cmp_t             g;

    always_comb
    begin
        k = s4_keep_reg;
        g = s4_cmp_reg;
        best_c[0] = k[0] & ~(k[1] & g.g01) & ~(k[2] & g.g02) & ~(k[3] & g.g03);
        best_c[1] = k[1] & (~k[0] | g.g01) & ~(k[2] & g.g12) & ~(k[3] & g.g13);
        best_c[2] = k[2] & (~k[0] | g.g02) & (~k[1] | g.g12) & ~(k[3] & g.g23);
        best_c[3] = k[3] & (~k[0] | g.g03) & (~k[1] | g.g13) & (~k[2] | g.g23);
    end

    // emitter: one result beat per cycle from the pending mask, while the output can load
    always_ff @(posedge clk)
    begin
        if (en_em)
        begin
            em_triv_reg <= s4_triv_reg;
            em_none_reg <= !s4_triv_reg && (s4_keep_reg == '0);
            em_pend_reg <= (s4_triv_reg || s4_keep_reg == '0) ? NCAND'(1) : s4_keep_reg;
            em_best_reg <= best_c;
            em_cand_reg <= s4_cand_reg;
            em_cnt_reg  <= s4_cnt_reg;
        end
        else if (em_fire)
        begin
            em_pend_reg <= em_pend_reg & ~em_sel;
        end
    end

    always_comb
    begin
        em_idx = '0;
        for (int i = NCAND - 1; i >= 0; i--)
        begin
            if (em_sel[i])
            begin
                em_idx = 2'(i);
            end
        end
    end

    always_comb
    begin
        dst_data_next.rotated_diff = em_cand_reg[em_idx];
        dst_data_next.count        = em_cnt_reg[em_idx];
        dst_data_next.is_best      = em_best_reg[em_idx];
        dst_data_next.none_kept    = 1'b0;
        dst_data_next.last         = em_last;
        if (em_triv_reg)
        begin
            // rotl(diff) equals diff here, and it sits in the c2 slot
            dst_data_next.rotated_diff = em_cand_reg[1];
            dst_data_next.count        = FULL_COUNT;
            dst_data_next.is_best      = 1'b1;
            dst_data_next.last         = 1'b1;
        end
        else if (em_none_reg)
        begin
            dst_data_next.rotated_diff = '0;
            dst_data_next.count        = '0;
            dst_data_next.is_best      = 1'b0;
            dst_data_next.none_kept    = 1'b1;
            dst_data_next.last         = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_fire)
        begin
            dst_data_reg <= dst_data_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

    // ---------------- assertions ----------------
    a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        em_valid_reg |-> (em_pend_reg != '0))
        else $error("emitter holds a beat with nothing pending");

    a_best_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (em_valid_reg && !em_triv_reg && !em_none_reg) |-> $onehot(em_best_reg))
        else $error("kept candidates without exactly one best");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (em_valid_reg && (em_triv_reg || em_none_reg)) |-> (em_pend_reg == NCAND'(1)))
        else $error("single-beat result with more than one beat pending");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (em_valid_reg && !out_load) |=> ($stable(em_pend_reg) && em_valid_reg))
        else $error("emitter advanced while output stalled");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for modular_difference_rotation_core: directed table plus random beats vs. predictor.
module tb;
    import mdr_pkg::*;

    localparam dst_beat_t NONE_BEAT = {32'h0000_0000, 33'h0_0000_0000, 3'b011};

    typedef struct packed {
        logic [COUNT_W-1:0] floor_val;
        src_beat_t          beat;
        logic               typed;
        dst_beat_t          want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_ready;
    src_beat_t          src_data = '0;
    logic               dst_valid;
    logic               dst_ready = 1'b0;
    dst_beat_t          dst_data;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;

    logic [COUNT_W-1:0] keep_floor = MIN_COUNT_RST;
    dst_beat_t          pending_cands[$];
    stim_row_t          stim_rows[$];
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 mismatches = 0;

    modular_difference_rotation_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        dst_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Expected candidate beats for one input beat, queued in emission order.
    function automatic void rotate_candidates(input src_beat_t b);
        logic [DIFF_W-1:0]  d;
        logic [DIFF_W-1:0]  x;
        logic [DIFF_W-1:0]  y;
        logic [DIFF_W-1:0]  yn;
        logic [DIFF_W-1:0]  base;
        logic [COUNT_W-1:0] lowspan;
        logic [COUNT_W-1:0] highspan;
        logic [DIFF_W-1:0]  cval [4];
        logic [COUNT_W-1:0] ccnt [4];
        int                 sh;
        int                 nc;
        int                 best;
        int                 kept[$];
        dst_beat_t          o;
        d = b.diff;
        if (d == '0 || b.rotation == '0)
        begin
            o = {d, FULL_COUNT, 3'b101};
            pending_cands = {pending_cands, o};
            return;
        end
        sh       = 32 - int'(b.rotation);
        lowspan  = 33'd1 << sh;
        highspan = 33'd1 << b.rotation;
        y        = d >> sh;
        x        = d & (lowspan[31:0] - 32'd1);
        base     = x << b.rotation;
        cval[0]  = (base | y) - highspan[31:0];
        ccnt[0]  = (lowspan - {1'b0, x}) * {1'b0, y};
        cval[1]  = base | y;
        ccnt[1]  = (lowspan - {1'b0, x}) * (highspan - {1'b0, y});
        nc = 2;
        if (x != '0)
        begin
            // high part wraps to zero when it is all ones
            yn      = (y + 32'd1) & (highspan[31:0] - 32'd1);
            cval[2] = (base | yn) - highspan[31:0];
            ccnt[2] = {1'b0, x} * {1'b0, yn};
            cval[3] = base | yn;
            ccnt[3] = {1'b0, x} * highspan - ccnt[2];
            nc = 4;
        end
        best = -1;
        for (int i = 0; i < nc; i++)
        begin
            if (ccnt[i] >= keep_floor)
            begin
                kept = {kept, i};
                if (best < 0 || ccnt[i] > ccnt[best])
                    best = i;
            end
        end
        if (kept.size() == 0)
        begin
            pending_cands = {pending_cands, NONE_BEAT};
            return;
        end
        for (int i = 0; i < kept.size(); i++)
        begin
            o.rotated_diff = cval[kept[i]];
            o.count        = ccnt[kept[i]];
            o.is_best      = (kept[i] == best);
            o.none_kept    = 1'b0;
            o.last         = (i == kept.size() - 1);
            pending_cands = {pending_cands, o};
        end
    endfunction

    function automatic src_beat_t pick_random_beat();
        src_beat_t b;
        int        sh;
        b.diff     = $urandom;
        b.rotation = $urandom_range(1, 31);
        sh         = 32 - int'(b.rotation);
        case ($urandom_range(0, 9))
            0: b.diff = '0;
            1: b.rotation = '0;
            2: b.diff = (b.diff >> sh) << sh;
            3: b.diff = b.diff | ~((32'd1 << sh) - 32'd1);
            4: b.diff = $urandom_range(1, 15);
            5: b.diff = ~($urandom_range(0, 15));
            default: ;
        endcase
        return b;
    endfunction

    task automatic add_row(input logic [COUNT_W-1:0] fl, input logic [DIFF_W-1:0] d,
                           input logic [ROT_W-1:0] r, input logic typed, input dst_beat_t want);
        stim_row_t row;
        row.floor_val = fl;
        row.beat      = {d, r};
        row.typed     = typed;
        row.want      = want;
        stim_rows = {stim_rows, row};
    endtask

    // Called just after a rising edge; returns at the edge where the beat is taken.
    task automatic push_item(input src_beat_t b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= b;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        while (pending_cands.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_floor(input logic [COUNT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        keep_floor = v;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
        begin
            if (pending_cands.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected beat: diff=%h count=%h best=%b none=%b last=%b",
                             dst_data.rotated_diff, dst_data.count, dst_data.is_best,
                             dst_data.none_kept, dst_data.last);
                mismatches++;
            end
            else
            begin
                dst_beat_t want;
                want = pending_cands.pop_front();
                if (dst_data.rotated_diff !== want.rotated_diff || dst_data.count !== want.count
                    || dst_data.is_best !== want.is_best || dst_data.none_kept !== want.none_kept
                    || dst_data.last !== want.last)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp diff=%h count=%h best=%b none=%b last=%b / got diff=%h count=%h best=%b none=%b last=%b",
                                 want.rotated_diff, want.count, want.is_best, want.none_kept,
                                 want.last, dst_data.rotated_diff, dst_data.count,
                                 dst_data.is_best, dst_data.none_kept, dst_data.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("** modular_difference_rotation_core: FAILED **");
        $finish;
    end

    initial
    begin
        logic [COUNT_W-1:0] thr;
        stim_row_t          row;

        // trivial inputs, extremes, zero low part, zero counts, nothing kept, ties
        add_row(33'd1, 32'h0000_0000, 5'd0, 1'b1, {32'h0000_0000, FULL_COUNT, 3'b101});
        add_row(33'd1, 32'h0000_0000, 5'd31, 1'b1, {32'h0000_0000, FULL_COUNT, 3'b101});
        add_row(33'd1, 32'hFFFF_FFFF, 5'd0, 1'b1, {32'hFFFF_FFFF, FULL_COUNT, 3'b101});
        add_row(33'd1, 32'h0000_0001, 5'd1, 1'b0, '0);
        add_row(33'd1, 32'hFFFF_FFFF, 5'd31, 1'b0, '0);
        add_row(33'd1, 32'hFFFF_FFFF, 5'd1, 1'b0, '0);
        add_row(33'd1, 32'h8000_0000, 5'd1, 1'b0, '0);
        add_row(33'd1, 32'h0000_0001, 5'd31, 1'b0, '0);
        add_row(33'd1, 32'h1234_5678, 5'd13, 1'b0, '0);
        add_row(33'd0, 32'h0000_0001, 5'd1, 1'b0, '0);
        add_row(33'd0, 32'hF000_0000, 5'd4, 1'b0, '0);
        add_row(33'd0, 32'h7FFF_FFFF, 5'd31, 1'b0, '0);
        add_row(FULL_COUNT, 32'h0000_0000, 5'd7, 1'b1, {32'h0000_0000, FULL_COUNT, 3'b101});
        add_row(FULL_COUNT, 32'hABCD_EF01, 5'd9, 1'b1, NONE_BEAT);
        add_row(33'h1_FFFF_FFFF, 32'h0000_0005, 5'd0, 1'b1, {32'h0000_0005, FULL_COUNT, 3'b101});
        add_row(33'h1_FFFF_FFFF, 32'h7FFF_FFFF, 5'd16, 1'b1, NONE_BEAT);
        add_row(33'h0_8000_0000, 32'h8000_0000, 5'd1, 1'b0, '0);
        add_row(33'h0_8000_0000, 32'h4000_0000, 5'd2, 1'b0, '0);
        add_row(33'h0_8000_0001, 32'h8000_0000, 5'd1, 1'b1, NONE_BEAT);
        add_row(33'h0_4000_0000, 32'h5555_5555, 5'd17, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 73;
        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.floor_val != keep_floor)
            begin
                drain();
                write_floor(row.floor_val);
            end
            push_item(row.beat);
            if (row.typed)
                pending_cands = {pending_cands, row.want};
            else
                rotate_candidates(row.beat);
        end

        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: thr = 33'd1;
                1: thr = 33'd1 << $urandom_range(16, 31);
                2: thr = 33'd0;
                3: thr = {1'b0, $urandom};
                4: thr = FULL_COUNT;
                5: thr = 33'd2;
                6: thr = 33'h1_FFFF_FFFF;
                7: thr = 33'd1 << $urandom_range(24, 32);
                default: thr = {1'b0, $urandom} >> $urandom_range(0, 12);
            endcase
            drain();
            write_floor(thr);
            if (p < 3)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 73;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 73;
                rx_idle_pct = 10;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < 36; n++)
            begin
                src_beat_t b;
                b = pick_random_beat();
                push_item(b);
                rotate_candidates(b);
            end
        end

        drain();
        if (mismatches == 0)
            $display("** modular_difference_rotation_core: PASSED **");
        else
            $display("** modular_difference_rotation_core: FAILED **");
        $finish;
    end

endmodule

// ----- modular_difference_rotation_core.f -----
rtl/core/mdr_pkg.sv
rtl/core/modular_difference_rotation_core.sv
tb/tb.sv
